### design/bom_pkg.sv
`default_nettype none

package bom_pkg;

  localparam int unsigned MaxWidthDefault  = 1024;
  localparam int unsigned MaxHeightDefault = 1024;

  localparam int unsigned PixelW  = 32;
  localparam int unsigned RgbW    = 24;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned DimW     = 11;
  localparam int unsigned ChanW    = 3;

  localparam logic [CfgIdxW-1:0] CfgImageWidth      = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgImageHeight     = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgChannelCount    = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgBackgroundColor = 3'd3;

  localparam logic [DimW-1:0]   ImageWidthReset   = 11'd1024;
  localparam logic [DimW-1:0]   ImageHeightReset  = 11'd1024;
  localparam logic [ChanW-1:0]  ChannelCountReset = 3'd3;
  localparam logic [PixelW-1:0] BackgroundReset   = 32'd0;

  localparam logic [RgbW-1:0] WhiteRgb = 24'hFF_FFFF;
  localparam logic [RgbW-1:0] BlackRgb = 24'h00_0000;

  // one line buffer entry: background bit of the row above and of the output row
  typedef struct packed {
    logic prev;
    logic cur;
  } bom_entry_t;

  function automatic logic [PixelW-1:0] chan_mask(input logic [ChanW-1:0] cnt);
    logic [PixelW-1:0] m;
    case (cnt)
      3'd0, 3'd1: m = 32'h0000_00FF;
      3'd2:       m = 32'h0000_FFFF;
      3'd3:       m = 32'h00FF_FFFF;
      default:    m = 32'hFFFF_FFFF;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

### design/bom_if.sv
`default_nettype none

interface bom_in_if;
  logic                       valid;
  logic                       ready;
  logic                       func;
  logic [bom_pkg::PixelW-1:0] pixel_value;

  modport source (output valid, output func, output pixel_value, input ready);
  modport sink   (input valid, input func, input pixel_value, output ready);
endinterface

interface bom_out_if;
  logic                     valid;
  logic                     ready;
  logic [bom_pkg::RgbW-1:0] outline_rgb;
  logic                     frame_end;

  modport source (output valid, output outline_rgb, output frame_end, input ready);
  modport sink   (input valid, input outline_rgb, input frame_end, output ready);
endinterface

`default_nettype wire

### design/background_outline_mask.sv
// Channel  Dir  Payload                          Beat when
// in_ch    in   func, pixel_value[31:0]          valid & ready
// out_ch   out  outline_rgb[23:0], frame_end     valid & ready
// cfg      in   cfg_idx_i[2:0], cfg_data_i[31:0] cfg_we_i
//
// One item per cycle unless out_ch stalls; results reach out_ch the next cycle.
// The rate is set by the line buffer: one write and one read port, with a
// three-entry lookahead window so every column decision has its neighbors ready.
// in_ch.ready is high while the output register is empty or being taken.
// After reset the line buffers are unknown; they are filled by the first two
// rows of a frame before any result depends on them. No clearing pass.
`default_nettype none

module background_outline_mask #(
  parameter int unsigned MAX_WIDTH  = bom_pkg::MaxWidthDefault,
  parameter int unsigned MAX_HEIGHT = bom_pkg::MaxHeightDefault
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            cfg_we_i,
  input  wire [bom_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  wire [bom_pkg::CfgDataW-1:0]    cfg_data_i,
  bom_in_if.sink                         in_ch,
  bom_out_if.source                      out_ch
);

  localparam int unsigned AW  = $clog2(MAX_WIDTH);
  localparam int unsigned WCW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned SW  = WCW + 1;
  localparam int unsigned HW  = $clog2(MAX_HEIGHT + 1);

  // configuration
  logic [bom_pkg::DimW-1:0]   width_q, height_q;
  logic [bom_pkg::ChanW-1:0]  chan_q;
  logic [bom_pkg::PixelW-1:0] color_q;
  logic                       cfg_hit;

  // frame position and line buffer window
  logic [AW-1:0]       col_q, col_d;
  logic [HW-1:0]       row_q, row_d;
  logic                left_q, left_d;
  bom_pkg::bom_entry_t w0_q, w1_q, rd_q;
  bom_pkg::bom_entry_t mem [MAX_WIDTH];

  // output register
  logic                     out_valid_q, out_valid_d;
  logic [bom_pkg::RgbW-1:0] out_rgb_q;
  logic                     out_end_q;

  logic [31:0]      wr32, hr32, w32, h32;
  logic [WCW-1:0]   width_eff, col_ext, col_nxt;
  logic [HW-1:0]    height_eff;
  logic [SW-1:0]    ahead;
  logic [AW-1:0]    raddr;
  logic             in_acc, is_drain, pix_act, drn_act, advance, last_col;
  logic             bg, produce, has_up, has_down, down_bg, hit, mem_we;
  logic             hit1, hit2, hit3;
  bom_pkg::bom_entry_t wentry;

  assign cfg_hit = cfg_we_i && (cfg_idx_i == bom_pkg::CfgImageWidth ||
                                cfg_idx_i == bom_pkg::CfgImageHeight ||
                                cfg_idx_i == bom_pkg::CfgChannelCount ||
                                cfg_idx_i == bom_pkg::CfgBackgroundColor);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= bom_pkg::ImageWidthReset;
      height_q <= bom_pkg::ImageHeightReset;
      chan_q   <= bom_pkg::ChannelCountReset;
      color_q  <= bom_pkg::BackgroundReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        bom_pkg::CfgImageWidth:      width_q  <= cfg_data_i[bom_pkg::DimW-1:0];
        bom_pkg::CfgImageHeight:     height_q <= cfg_data_i[bom_pkg::DimW-1:0];
        bom_pkg::CfgChannelCount:    chan_q   <= cfg_data_i[bom_pkg::ChanW-1:0];
        bom_pkg::CfgBackgroundColor: color_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // zero acts as one, oversize clamps to MAX_WIDTH or MAX_HEIGHT
  always_comb begin
    wr32 = 32'(width_q);
    hr32 = 32'(height_q);
    if (wr32 == 32'd0) w32 = 32'd1;
    else if (wr32 > 32'(MAX_WIDTH)) w32 = 32'(MAX_WIDTH);
    else w32 = wr32;
    if (hr32 == 32'd0) h32 = 32'd1;
    else if (hr32 > 32'(MAX_HEIGHT)) h32 = 32'(MAX_HEIGHT);
    else h32 = hr32;
    width_eff  = w32[WCW-1:0];
    height_eff = h32[HW-1:0];
  end

  assign in_ch.ready = !out_valid_q || out_ch.ready;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign is_drain    = in_ch.func;
  assign pix_act     = !is_drain && (row_q < height_eff);
  assign drn_act     = is_drain && (row_q >= height_eff);
  assign advance     = in_acc && (pix_act || drn_act);

  assign col_ext  = WCW'(col_q);
  assign col_nxt  = col_ext + WCW'(1);
  assign last_col = (col_nxt == width_eff);

  assign bg = ((in_ch.pixel_value ^ color_q) & bom_pkg::chan_mask(chan_q)) == '0;

  assign produce  = advance && (drn_act || row_q != '0);
  assign has_up   = drn_act ? (height_eff > HW'(1)) : (row_q > HW'(1));
  assign has_down = pix_act;
  assign down_bg  = bg;

  always_comb begin
    hit = 1'b0;
    if (col_q != '0 && !left_q) hit = 1'b1;
    if (!last_col && !w1_q.cur) hit = 1'b1;
    if (has_up && !w0_q.prev) hit = 1'b1;
    if (has_down && !down_bg) hit = 1'b1;
    hit = hit && w0_q.cur;
  end

  // window wrap: an entry of the window aliases the written column on tiny rows
  assign hit1 = (width_eff == WCW'(1));
  assign hit2 = (width_eff <= WCW'(2));
  assign hit3 = (width_eff == WCW'(1)) || (width_eff == WCW'(3));

  always_comb begin
    ahead = SW'(col_q) + SW'(3);
    if (width_eff == WCW'(1)) raddr = '0;
    else if (width_eff == WCW'(2)) raddr = AW'(~col_q[0]);
    else if (ahead >= SW'(width_eff)) raddr = AW'(ahead - SW'(width_eff));
    else raddr = AW'(ahead);
  end

  assign mem_we      = advance && pix_act;
  assign wentry.prev = w0_q.cur;
  assign wentry.cur  = bg;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[col_q] <= wentry;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      w0_q <= (mem_we && hit1) ? wentry : w1_q;
      w1_q <= (mem_we && hit2) ? wentry : rd_q;
      rd_q <= (mem_we && hit3) ? wentry : mem[raddr];
    end
  end

  always_comb begin
    col_d  = col_q;
    row_d  = row_q;
    left_d = left_q;
    if (advance) begin
      left_d = w0_q.cur;
      if (last_col) begin
        col_d = '0;
        if (pix_act) begin
          row_d = row_q + HW'(1);
        end else begin
          row_d  = '0;
          left_d = 1'b0;
        end
      end else begin
        col_d = col_q + AW'(1);
      end
    end
    if (cfg_hit) begin
      col_d  = '0;
      row_d  = '0;
      left_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      left_q <= 1'b0;
    end else begin
      col_q  <= col_d;
      row_q  <= row_d;
      left_q <= left_d;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q && !out_ch.ready;
    if (produce) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (produce) begin
      out_rgb_q <= hit ? bom_pkg::WhiteRgb : bom_pkg::BlackRgb;
      out_end_q <= drn_act && last_col;
    end
  end

  assign out_ch.valid       = out_valid_q;
  assign out_ch.outline_rgb = out_rgb_q;
  assign out_ch.frame_end   = out_end_q;

  a_col_in_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_ext < width_eff)
    else $error("column position beyond row width");

  a_row_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_q <= height_eff)
    else $error("row position beyond frame height");

  a_frame_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && drn_act && last_col) |=> (row_q == '0 && col_q == '0))
    else $error("frame did not restart after last drain beat");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ch.ready) |-> !produce)
    else $error("result produced while output register is held");

endmodule

`default_nettype wire

### bench/bom_tb_pkg.sv
`timescale 1ns / 1ps

package bom_tb_pkg;
  import bom_pkg::*;

  localparam logic FuncPixel = 1'b0;
  localparam logic FuncDrain = 1'b1;

  localparam logic [CfgIdxW-1:0] CfgFirstUnused = CfgBackgroundColor + 3'd1;

  localparam int unsigned MaxReports = 200;

  typedef struct packed {
    logic [RgbW-1:0] rgb;
    logic            frame_end;
  } outline_beat_t;

  function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned vmax);
    if (v == 0) return 1;
    if (v > vmax) return vmax;
    return v;
  endfunction

  // bytes of a pixel that take part in the background compare
  function automatic logic [PixelW-1:0] compare_mask(input logic [ChanW-1:0] chans);
    int unsigned n;
    n = clamp_dim(32'(chans), 4);
    if (n == 4) return '1;
    return (32'd1 << (8 * n)) - 32'd1;
  endfunction

  class outline_tracker;
    logic [DimW-1:0]   width_reg;
    logic [DimW-1:0]   height_reg;
    logic [ChanW-1:0]  chan_reg;
    logic [PixelW-1:0] back_color;
    bit                above_bg [MaxWidthDefault];
    bit                row_bg   [MaxWidthDefault];
    bit                left_bg;
    int unsigned       col;
    int unsigned       row;
    int unsigned       drain_col;
    outline_beat_t     outlines_due[$];
    int unsigned       errors;
    int unsigned       beats_in;
    int unsigned       outlines_seen;
    int unsigned       frames_done;

    function new();
      width_reg  = ImageWidthReset;
      height_reg = ImageHeightReset;
      chan_reg   = ChannelCountReset;
      back_color = BackgroundReset;
      restart();
    endfunction

    function void restart();
      col       = 0;
      row       = 0;
      drain_col = 0;
      left_bg   = 1'b0;
    endfunction

    function int unsigned frame_width();
      return clamp_dim(32'(width_reg), MaxWidthDefault);
    endfunction

    function int unsigned frame_height();
      return clamp_dim(32'(height_reg), MaxHeightDefault);
    endfunction

    function void write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
      case (idx)
        CfgImageWidth:      width_reg  = data[DimW-1:0];
        CfgImageHeight:     height_reg = data[DimW-1:0];
        CfgChannelCount:    chan_reg   = data[ChanW-1:0];
        CfgBackgroundColor: back_color = data;
        default:            return;
      endcase
      restart();
    endfunction

    // background pixel with a foreground 4-neighbor inside the frame
    function bit is_outline(input int unsigned x, input int unsigned w, input bit has_up,
                            input bit has_down, input bit below_bg);
      if (!row_bg[x]) return 1'b0;
      return (x > 0 && !left_bg) || (x + 1 < w && !row_bg[x + 1]) ||
             (has_up && !above_bg[x]) || (has_down && !below_bg);
    endfunction

    function void note_beat(input logic func, input logic [PixelW-1:0] pix);
      int unsigned   w;
      int unsigned   h;
      int unsigned   x;
      bit            bg;
      outline_beat_t due;
      w = frame_width();
      h = frame_height();
      beats_in++;
      if (func == FuncPixel) begin
        x = col;
        if (row >= h || x >= w) return;
        bg = ((pix ^ back_color) & compare_mask(chan_reg)) == '0;
        if (row > 0) begin
          due.rgb       = is_outline(x, w, row > 1, 1'b1, bg) ? WhiteRgb : BlackRgb;
          due.frame_end = 1'b0;
          outlines_due  = {outlines_due, due};
        end
        left_bg     = row_bg[x];
        above_bg[x] = row_bg[x];
        row_bg[x]   = bg;
        col = x + 1;
        if (col >= w) begin
          col = 0;
          row++;
        end
      end else begin
        x = drain_col;
        if (row < h || x >= w) return;
        due.rgb = is_outline(x, w, h > 1, 1'b0, 1'b1) ? WhiteRgb : BlackRgb;
        left_bg   = row_bg[x];
        drain_col = x + 1;
        due.frame_end = drain_col >= w;
        outlines_due  = {outlines_due, due};
        if (due.frame_end) restart();
      end
    endfunction

    function void mismatch(input string what, input logic [RgbW-1:0] want,
                           input logic [RgbW-1:0] got);
      errors++;
      if (errors <= MaxReports)
        $display("%0t: %s mismatch, expected %h actual %h", $time, what, want, got);
    endfunction

    function void check_outline(input logic [RgbW-1:0] rgb, input logic fe);
      outline_beat_t want;
      if (outlines_due.size() == 0) begin
        mismatch("unexpected beat", '0, rgb);
        return;
      end
      want = outlines_due.pop_front();
      outlines_seen++;
      if (rgb !== want.rgb) mismatch("outline_rgb", want.rgb, rgb);
      if (fe !== want.frame_end) mismatch("frame_end", RgbW'(want.frame_end), RgbW'(fe));
      if (want.frame_end) frames_done++;
    endfunction
  endclass

endpackage

### bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import bom_pkg::*;
  import bom_tb_pkg::*;

  localparam int unsigned RandomBeats   = 650;
  localparam int unsigned CycleLimit    = 400000;
  localparam int unsigned SettleCycles  = 4;
  localparam int unsigned HoldOffCycles = 150;

  typedef enum int unsigned {IdleNone, IdleSource, IdleSink, IdleBoth} idle_mode_e;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  int unsigned src_idle_pct = 0;
  int unsigned rx_stall_pct = 0;
  logic        rx_hold = 1'b0;
  int unsigned cycles = 0;
  int unsigned stim_beats = 0;

  outline_tracker sb;

  bom_in_if  in_ch ();
  bom_out_if out_ch ();

  background_outline_mask u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_ch      (in_ch),
    .out_ch     (out_ch)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    out_ch.ready <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_ch.valid && in_ch.ready) sb.note_beat(in_ch.func, in_ch.pixel_value);
    if (rst_ni && out_ch.valid && out_ch.ready)
      sb.check_outline(out_ch.outline_rgb, out_ch.frame_end);
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("%0t: timed out, %0d outlines still due", $time, sb.outlines_due.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic set_idle(input idle_mode_e m);
    src_idle_pct = (m == IdleSource) ? 63 : (m == IdleBoth) ? 17 : 0;
    rx_stall_pct <= (m == IdleSink) ? 63 : (m == IdleBoth) ? 17 : 0;
  endtask

  task automatic send_beat(input logic func, input logic [PixelW-1:0] pix);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid       <= 1'b1;
    in_ch.func        <= func;
    in_ch.pixel_value <= pix;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    sb.write_reg(idx, data);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // wait until every due outline has come back, then let the pipe go quiet
  task automatic settle();
    in_ch.valid <= 1'b0;
    do @(negedge clk_i); while (sb.outlines_due.size() != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic hold_receiver(input int unsigned n);
    rx_hold <= 1'b1;
    repeat (n) @(posedge clk_i);
    rx_hold <= 1'b0;
  endtask

  function automatic logic [PixelW-1:0] make_pixel(input int unsigned bg_pct);
    logic [PixelW-1:0] mask;
    logic [PixelW-1:0] flip;
    mask = compare_mask(sb.chan_reg);
    flip = $urandom;
    if ($urandom_range(99) < bg_pct) return sb.back_color ^ (flip & ~mask);
    if ((flip & mask) == '0) flip[0] = 1'b1;
    return sb.back_color ^ flip;
  endfunction

  // raster pixels then drain beats, with a sprinkle of out-of-place beats the block drops
  task automatic stream_frame(input int unsigned bg_pct, input int unsigned stop_at);
    int unsigned w;
    int unsigned pixels;
    int unsigned n;
    w      = sb.frame_width();
    pixels = w * sb.frame_height();
    for (n = 0; n < stop_at && n < pixels + w; n++) begin
      if ($urandom_range(99) < 4) send_beat(n < pixels ? FuncDrain : FuncPixel, $urandom);
      if (n < pixels) send_beat(FuncPixel, make_pixel(bg_pct));
      else send_beat(FuncDrain, $urandom);
      stim_beats++;
    end
  endtask

  initial begin
    int unsigned frame_no;
    int unsigned wreg;
    int unsigned hreg;
    int unsigned stop_at;
    sb = new();
    rst_ni            <= 1'b0;
    cfg_we_i          <= 1'b0;
    cfg_idx_i         <= CfgImageWidth;
    cfg_data_i        <= '0;
    in_ch.valid       <= 1'b0;
    in_ch.func        <= FuncPixel;
    in_ch.pixel_value <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // 3x3 frame on two compared bytes
    write_reg(CfgImageWidth, 32'd3);
    write_reg(CfgImageHeight, 32'd3);
    write_reg(CfgChannelCount, 32'd2);
    write_reg(CfgBackgroundColor, 32'h1234_A55A);
    send_beat(FuncDrain, '1);
    send_beat(FuncPixel, 32'hFFFF_A55A);
    send_beat(FuncPixel, 32'h0000_0000);
    send_beat(FuncPixel, 32'h0000_A55A);
    send_beat(FuncPixel, 32'h1234_A55B);
    settle();
    // index past the register list: no restart, frame carries on
    write_reg(CfgFirstUnused, '1);
    send_beat(FuncPixel, 32'h5555_A55A);
    send_beat(FuncPixel, 32'hFFFF_FFFF);
    send_beat(FuncPixel, 32'h0000_A55A);
    send_beat(FuncPixel, 32'hA55A_A55A);
    send_beat(FuncPixel, 32'hA55A);
    send_beat(FuncPixel, 32'h00FF_5AA5);
    send_beat(FuncPixel, 32'hDEAD_BEEF);
    repeat (3) send_beat(FuncDrain, '0);
    settle();

    // zero sizes act as a single pixel
    write_reg(CfgImageWidth, 32'd0);
    write_reg(CfgImageHeight, 32'd0);
    send_beat(FuncPixel, '1);
    send_beat(FuncDrain, '1);
    send_beat(FuncPixel, 32'h0000_A55A);
    send_beat(FuncDrain, '0);
    settle();

    // one row, zero channels acts as one byte
    write_reg(CfgImageWidth, 32'd2);
    write_reg(CfgImageHeight, 32'd1);
    write_reg(CfgChannelCount, 32'd0);
    write_reg(CfgBackgroundColor, 32'd0);
    send_beat(FuncPixel, 32'h0000_0100);
    send_beat(FuncPixel, 32'h0000_0001);
    send_beat(FuncDrain, '0);
    send_beat(FuncDrain, '0);
    settle();

    // widest row (register above the max), cut short a few pixels into row 1
    write_reg(CfgImageWidth, 32'd2047);
    write_reg(CfgImageHeight, 32'd1024);
    write_reg(CfgChannelCount, 32'd4);
    write_reg(CfgBackgroundColor, '1);
    stream_frame(50, MaxWidthDefault + 8);
    settle();

    // long receiver hold-off while the source keeps pushing
    write_reg(CfgImageWidth, 32'd8);
    write_reg(CfgImageHeight, 32'd8);
    write_reg(CfgChannelCount, 32'd3);
    write_reg(CfgBackgroundColor, $urandom);
    fork
      hold_receiver(HoldOffCycles);
    join_none
    stream_frame(50, '1);
    settle();

    stim_beats = 0;
    frame_no   = 0;
    while (stim_beats < RandomBeats) begin
      set_idle(idle_mode_e'(frame_no % 4));
      case ($urandom_range(19))
        0:       wreg = 0;
        1:       wreg = $urandom_range(1025, 2047);
        2:       wreg = 1024;
        default: wreg = $urandom_range(1, 10);
      endcase
      hreg = ($urandom_range(19) == 0) ? $urandom_range(1025, 2047) : $urandom_range(0, 6);
      write_reg(CfgImageWidth, wreg);
      if ($urandom_range(9) < 6) write_reg(CfgImageHeight, hreg);
      if ($urandom_range(9) < 6) write_reg(CfgChannelCount, $urandom_range(0, 7));
      if ($urandom_range(9) < 6) begin
        case ($urandom_range(3))
          0:       write_reg(CfgBackgroundColor, '0);
          1:       write_reg(CfgBackgroundColor, '1);
          default: write_reg(CfgBackgroundColor, $urandom);
        endcase
      end
      if ($urandom_range(9) == 0)
        write_reg(CfgIdxW'(CfgFirstUnused + $urandom_range(0, 3)), $urandom);
      if (sb.frame_width() * sb.frame_height() > 200) stop_at = $urandom_range(1, 200);
      else if ($urandom_range(9) == 0) stop_at = $urandom_range(1, 40);
      else stop_at = '1;
      stream_frame($urandom_range(25, 75), stop_at);
      settle();
      frame_no++;
    end

    repeat (10) @(posedge clk_i);
    $display("Sent %0d input beats, checked %0d outline results over %0d whole frames",
             sb.beats_in, sb.outlines_seen, sb.frames_done);
    $display("Sizes 0..10 and clamped extremes, channel counts 0..7, four idle mixes, hold-off");
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
